// ----- rtl/core/ising_metropolis_spin_update_defines.svh -----
// Assertion macros used by the spin update checker
`ifndef ISING_METROPOLIS_SPIN_UPDATE_DEFINES_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ISM_ASSERT_HOLDS(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ISM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ism_pkg.sv -----
// Shared types and constants of the Ising spin update block
`timescale 1ns / 1ps
package ism_pkg;

	localparam int OP_W     = 2;
	localparam int ROW_W    = 6;
	localparam int FRAC_W   = 32;
	localparam int DE_W     = 5;
	localparam int E_OUT_W  = 15;
	localparam int M_OUT_W  = 14;
	localparam int SUM_W    = 64;
	localparam int SQ_W     = 63;
	localparam int CNT_W    = 32;
	localparam int SIDE_W   = 7;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;
	localparam int NB_SPINS = 5;
	localparam int SEL_W    = 3;

	localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd16;

	localparam logic [OP_W-1:0] OP_FLIP    = 2'd0;
	localparam logic [OP_W-1:0] OP_SWEEP   = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] REG_SIDE = 2'd0;
	localparam logic [1:0] REG_R4   = 2'd1;
	localparam logic [1:0] REG_R8   = 2'd2;

	// read order of the five lattice sites
	localparam logic [SEL_W-1:0] SEL_MID = 3'd0;
	localparam logic [SEL_W-1:0] SEL_UP  = 3'd1;
	localparam logic [SEL_W-1:0] SEL_DN  = 3'd2;
	localparam logic [SEL_W-1:0] SEL_LF  = 3'd3;
	localparam logic [SEL_W-1:0] SEL_RT  = 3'd4;

	typedef struct packed {
		logic             take;
		logic             restart;
		logic             clr_wr;
		logic [SEL_W-1:0] rd_sel;
		logic             cap;
		logic [SEL_W-1:0] cap_sel;
		logic             eval;
		logic             upd;
		logic             sq;
		logic             sum;
		logic             load_out;
	} ism_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            site_ok;
		logic            clr_last;
	} ism_status_t;

endpackage

// ----- rtl/core/ism_if.sv -----
// Request and result channel interfaces of the spin update block
`timescale 1ns / 1ps
interface ism_item_if import ism_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ROW_W-1:0]  row;
	logic [ROW_W-1:0]  col;
	logic [FRAC_W-1:0] rand_fraction;

	modport source (output valid, output op, output row, output col, output rand_fraction,
		input ready);
	modport sink (input valid, input op, input row, input col, input rand_fraction,
		output ready);
endinterface

interface ism_result_if import ism_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic signed [DE_W-1:0]    energy_change;
	logic signed [E_OUT_W-1:0] energy;
	logic signed [M_OUT_W-1:0] magnetization;
	logic signed [SUM_W-1:0]   sum_energy;
	logic [SQ_W-1:0]           sum_energy_sq;
	logic signed [SUM_W-1:0]   sum_mag;
	logic [SQ_W-1:0]           sum_mag_sq;
	logic [SQ_W-1:0]           sum_abs_mag;
	logic [CNT_W-1:0]          sweeps_done;

	modport source (output valid, output accepted, output energy_change, output energy,
		output magnetization, output sum_energy, output sum_energy_sq, output sum_mag,
		output sum_mag_sq, output sum_abs_mag, output sweeps_done, input ready);
	modport sink (input valid, input accepted, input energy_change, input energy,
		input magnetization, input sum_energy, input sum_energy_sq, input sum_mag,
		input sum_mag_sq, input sum_abs_mag, input sweeps_done, output ready);
endinterface

// ----- rtl/core/ism_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module ism_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/ism_ctrl.sv -----
// Sequencer for flip attempts, sweep sums, restart and lattice clearing
`timescale 1ns / 1ps
module ism_ctrl import ism_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	output logic        result_valid,
	input  logic        result_ready,
	input  logic        side_wr,
	input  ism_status_t status,
	output ism_cmd_t    cmd
);
	localparam logic [3:0] S_RST  = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_IDLE = 4'd2;
	localparam logic [3:0] S_DEC  = 4'd3;
	localparam logic [3:0] S_RD   = 4'd4;
	localparam logic [3:0] S_EVAL = 4'd5;
	localparam logic [3:0] S_UPD  = 4'd6;
	localparam logic [3:0] S_SQ   = 4'd7;
	localparam logic [3:0] S_SUM  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	localparam logic [SEL_W-1:0] RD_LAST = SEL_W'(NB_SPINS);

	logic [3:0]       state_q, state_nxt;
	logic [SEL_W-1:0] rd_cnt_q, rd_cnt_nxt;
	logic             reply_q, reply_nxt;
	logic             out_valid_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		rd_cnt_nxt = rd_cnt_q;
		reply_nxt  = reply_q;
		case (state_q)
			S_RST: begin
				cmd.restart = 1'b1;
				state_nxt   = S_CLR;
			end
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_nxt = reply_q ? S_FIN : S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.take  = 1'b1;
					state_nxt = S_DEC;
				end
			end
			S_DEC: begin
				case (status.op)
					OP_FLIP: begin
						rd_cnt_nxt = '0;
						state_nxt  = status.site_ok ? S_RD : S_FIN;
					end
					OP_SWEEP: state_nxt = S_SQ;
					OP_RESTART: begin
						reply_nxt = 1'b1;
						state_nxt = S_RST;
					end
					default: state_nxt = S_FIN;
				endcase
			end
			S_RD: begin
				// read data arrives in the cycle after its address
				cmd.rd_sel  = rd_cnt_q;
				cmd.cap     = (rd_cnt_q != '0);
				cmd.cap_sel = rd_cnt_q - SEL_W'(1);
				if (rd_cnt_q == RD_LAST) begin
					state_nxt = S_EVAL;
				end else begin
					rd_cnt_nxt = rd_cnt_q + SEL_W'(1);
				end
			end
			S_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = S_UPD;
			end
			S_UPD: begin
				cmd.upd   = 1'b1;
				state_nxt = S_FIN;
			end
			S_SQ: begin
				cmd.sq    = 1'b1;
				state_nxt = S_SUM;
			end
			S_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					reply_nxt    = 1'b0;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_RST;
		endcase
		// new side: reload energy, magnetization and clear the lattice
		if (side_wr) begin
			state_nxt = S_RST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RST;
			rd_cnt_q    <= '0;
			reply_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			rd_cnt_q <= rd_cnt_nxt;
			reply_q  <= reply_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ----- rtl/core/ism_dp.sv -----
// Datapath: spin lattice RAM, energy change, running totals and sweep sums
`timescale 1ns / 1ps
module ism_dp import ism_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  logic                      clk,
	input  ism_cmd_t                  cmd,
	output ism_status_t               status,
	input  logic [OP_W-1:0]           op,
	input  logic [ROW_W-1:0]          row,
	input  logic [ROW_W-1:0]          col,
	input  logic [FRAC_W-1:0]         rand_fraction,
	input  logic [SIDE_W-1:0]         side,
	input  logic [FRAC_W-1:0]         ratio_4,
	input  logic [FRAC_W-1:0]         ratio_8,
	output logic                      res_accepted,
	output logic signed [DE_W-1:0]    res_energy_change,
	output logic signed [E_OUT_W-1:0] res_energy,
	output logic signed [M_OUT_W-1:0] res_magnetization,
	output logic signed [SUM_W-1:0]   res_sum_energy,
	output logic [SQ_W-1:0]           res_sum_energy_sq,
	output logic signed [SUM_W-1:0]   res_sum_mag,
	output logic [SQ_W-1:0]           res_sum_mag_sq,
	output logic [SQ_W-1:0]           res_sum_abs_mag,
	output logic [CNT_W-1:0]          res_sweeps_done
);
	localparam int IW    = $clog2(MAX_SIDE);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int SB    = $clog2(MAX_SIDE + 1);
	localparam int MW    = 2 * SB;
	localparam int EW    = 2 * SB + 1;
	localparam int EW2   = 2 * EW;
	localparam int MW2   = 2 * MW;

	logic [OP_W-1:0]     op_q;
	logic [ROW_W-1:0]    row_q, col_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [NB_SPINS-1:0] spin_q;
	logic                acc_q;
	logic [DE_W-1:0]     de_q;
	logic signed [EW-1:0] energy_q;
	logic signed [MW-1:0] mag_q;
	logic [SUM_W-1:0]    sum_e_q, sum_m_q;
	logic [SQ_W-1:0]     sum_esq_q, sum_msq_q, sum_abs_q;
	logic [CNT_W-1:0]    sweeps_q;
	logic [AW-1:0]       clr_cnt_q;
	logic [EW2-1:0]      e_sq_s1;
	logic [MW2-1:0]      m_sq_s1;
	logic [MW-1:0]       m_abs_s1;

	logic [SB-1:0]       side_eff;
	logic [MW-1:0]       n_sites;
	logic [IW-1:0]       r_i, c_i, sm1, up_i, dn_i, lf_i, rt_i;
	logic [2:0]          eq_n;
	logic                ok;
	logic signed [EW2-1:0] e_ext;
	logic signed [MW2-1:0] m_ext;
	logic [SUM_W:0]      se_sum, sm_sum;
	logic [SQ_W:0]       esq_sum, msq_sum, abs_sum;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [0:0]    ram_wdata, ram_rdata;

	// side clamped to the supported range
	always_comb begin
		if (side < SIDE_W'(2)) begin
			side_eff = SB'(2);
		end else if (32'(side) > MAX_SIDE) begin
			side_eff = SB'(MAX_SIDE);
		end else begin
			side_eff = SB'(side);
		end
	end

	assign n_sites = MW'(side_eff) * MW'(side_eff);

	// wrapped neighbour indices
	assign r_i  = IW'(row_q);
	assign c_i  = IW'(col_q);
	assign sm1  = IW'(side_eff - SB'(1));
	assign up_i = (r_i == '0) ? sm1 : r_i - IW'(1);
	assign dn_i = (r_i == sm1) ? '0 : r_i + IW'(1);
	assign lf_i = (c_i == '0) ? sm1 : c_i - IW'(1);
	assign rt_i = (c_i == sm1) ? '0 : c_i + IW'(1);

	assign status.op       = op_q;
	assign status.site_ok  = (32'(row_q) < 32'(side_eff)) && (32'(col_q) < 32'(side_eff));
	assign status.clr_last = (clr_cnt_q == '1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {r_i, c_i};
		ram_wdata = ~spin_q[SEL_MID];
		if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = 1'b1;
		end else if (cmd.upd && acc_q) begin
			ram_we = 1'b1;
		end
		case (cmd.rd_sel)
			SEL_MID: ram_raddr = {r_i, c_i};
			SEL_UP:  ram_raddr = {up_i, c_i};
			SEL_DN:  ram_raddr = {dn_i, c_i};
			SEL_LF:  ram_raddr = {r_i, lf_i};
			SEL_RT:  ram_raddr = {r_i, rt_i};
			default: ram_raddr = {r_i, c_i};
		endcase
	end

	ism_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_lattice (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// dE = 4 * (neighbours equal to centre) - 8
	assign eq_n = 3'($countones(~(spin_q[NB_SPINS-1:1] ^ {(NB_SPINS-1){spin_q[SEL_MID]}})));
	assign ok   = (eq_n <= 3'd2) || ((eq_n == 3'd3) && (frac_q <= ratio_4)) ||
		((eq_n == 3'd4) && (frac_q <= ratio_8));

	assign e_ext = EW2'(energy_q);
	assign m_ext = MW2'(mag_q);

	assign se_sum  = {sum_e_q[SUM_W-1], sum_e_q} + (SUM_W+1)'(energy_q);
	assign sm_sum  = {sum_m_q[SUM_W-1], sum_m_q} + (SUM_W+1)'(mag_q);
	assign esq_sum = {1'b0, sum_esq_q} + (SQ_W+1)'(e_sq_s1);
	assign msq_sum = {1'b0, sum_msq_q} + (SQ_W+1)'(m_sq_s1);
	assign abs_sum = {1'b0, sum_abs_q} + (SQ_W+1)'(m_abs_s1);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= op;
			row_q  <= row;
			col_q  <= col;
			frac_q <= rand_fraction;
			acc_q  <= 1'b0;
			de_q   <= '0;
		end
		if (cmd.cap) begin
			spin_q[cmd.cap_sel] <= ram_rdata[0];
		end
		if (cmd.eval) begin
			acc_q <= ok;
			de_q  <= {eq_n, 2'b00} - DE_W'(8);
		end
		if (cmd.restart) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
		if (cmd.sq) begin
			e_sq_s1  <= EW2'(e_ext * e_ext);
			m_sq_s1  <= MW2'(m_ext * m_ext);
			m_abs_s1 <= mag_q[MW-1] ? MW'(-mag_q) : MW'(mag_q);
		end

		if (cmd.restart) begin
			energy_q  <= EW'(0) - {n_sites, 1'b0};
			mag_q     <= n_sites;
			sum_e_q   <= '0;
			sum_m_q   <= '0;
			sum_esq_q <= '0;
			sum_msq_q <= '0;
			sum_abs_q <= '0;
			sweeps_q  <= '0;
		end else if (cmd.upd && acc_q) begin
			energy_q <= energy_q + EW'($signed(de_q));
			mag_q    <= spin_q[SEL_MID] ? mag_q - MW'(2) : mag_q + MW'(2);
		end else if (cmd.sum) begin
			if (se_sum[SUM_W] != se_sum[SUM_W-1]) begin
				sum_e_q <= se_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				sum_e_q <= se_sum[SUM_W-1:0];
			end
			if (sm_sum[SUM_W] != sm_sum[SUM_W-1]) begin
				sum_m_q <= sm_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
			end else begin
				sum_m_q <= sm_sum[SUM_W-1:0];
			end
			sum_esq_q <= esq_sum[SQ_W] ? '1 : esq_sum[SQ_W-1:0];
			sum_msq_q <= msq_sum[SQ_W] ? '1 : msq_sum[SQ_W-1:0];
			sum_abs_q <= abs_sum[SQ_W] ? '1 : abs_sum[SQ_W-1:0];
			if (sweeps_q != '1) begin
				sweeps_q <= sweeps_q + CNT_W'(1);
			end
		end

		if (cmd.load_out) begin
			res_accepted      <= acc_q;
			res_energy_change <= de_q;
			res_energy        <= E_OUT_W'(energy_q);
			res_magnetization <= M_OUT_W'(mag_q);
			res_sum_energy    <= sum_e_q;
			res_sum_energy_sq <= sum_esq_q;
			res_sum_mag       <= sum_m_q;
			res_sum_mag_sq    <= sum_msq_q;
			res_sum_abs_mag   <= sum_abs_q;
			res_sweeps_done   <= sweeps_q;
		end
	end
endmodule

// ----- rtl/core/ising_metropolis_spin_update.sv -----
// Top level of the Ising Metropolis spin update block with its APB registers
//
//   channel  dir   handshake        payload
//   item     in    valid / ready    op, row, col, rand_fraction
//   result   out   valid / ready    accepted .. sweeps_done
//   apb      in    psel / penable   lattice_side, accept_ratio_4, accept_ratio_8
//
// Flip attempt: one request at a time, paced by five reads through the single read
// port of the spin RAM plus evaluate and write-back. Sweep: square then
// saturating add. Out-of-range site or unused op: decode, then the result.
// Reset and lattice_side write: item.ready low for a restart step and a clearing
// pass over the whole spin RAM (4096 entries by default). Restart request: restart, clearing pass, then its result.
// A waiting result does not stop the next request being taken.
`timescale 1ns / 1ps
module ising_metropolis_spin_update import ism_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	ism_item_if.sink          item,
	ism_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	logic [SIDE_W-1:0] side_q;
	logic [FRAC_W-1:0] ratio_4_q, ratio_8_q;
	logic              wr_en, side_wr;
	logic [1:0]        reg_idx;
	ism_cmd_t          cmd;
	ism_status_t       status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign side_wr = wr_en && (reg_idx == REG_SIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q    <= SIDE_RESET;
			ratio_4_q <= '0;
			ratio_8_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SIDE: side_q    <= pwdata[SIDE_W-1:0];
				REG_R4:   ratio_4_q <= pwdata[FRAC_W-1:0];
				REG_R8:   ratio_8_q <= pwdata[FRAC_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SIDE: prdata = APB_DW'(side_q);
			REG_R4:   prdata = APB_DW'(ratio_4_q);
			REG_R8:   prdata = APB_DW'(ratio_8_q);
			default:  prdata = '0;
		endcase
	end

	ism_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.side_wr      (side_wr),
		.status       (status),
		.cmd          (cmd)
	);

	ism_dp #(
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk               (clk),
		.cmd               (cmd),
		.status            (status),
		.op                (item.op),
		.row               (item.row),
		.col               (item.col),
		.rand_fraction     (item.rand_fraction),
		.side              (side_q),
		.ratio_4           (ratio_4_q),
		.ratio_8           (ratio_8_q),
		.res_accepted      (result.accepted),
		.res_energy_change (result.energy_change),
		.res_energy        (result.energy),
		.res_magnetization (result.magnetization),
		.res_sum_energy    (result.sum_energy),
		.res_sum_energy_sq (result.sum_energy_sq),
		.res_sum_mag       (result.sum_mag),
		.res_sum_mag_sq    (result.sum_mag_sq),
		.res_sum_abs_mag   (result.sum_abs_mag),
		.res_sweeps_done   (result.sweeps_done)
	);
endmodule

// ----- rtl/core/ism_checker.sv -----
// Port-level checker for the spin update block and its bind
`timescale 1ns / 1ps
`include "ising_metropolis_spin_update_defines.svh"
module ism_checker import ism_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   item_valid,
	input logic                   item_ready,
	input logic                   result_valid,
	input logic                   result_accepted,
	input logic signed [DE_W-1:0] result_energy_change,
	input logic                   psel,
	input logic                   penable,
	input logic                   pwrite,
	input logic [APB_AW-1:0]      paddr
);
	// ready is low in the cycle after a request is taken
	`ISM_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready, "ready held after request taken")

	// a lattice_side write starts a restart and clearing pass
	`ISM_ASSERT_NEXT(a_side_wr_restarts, psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_SIDE), !item_ready, "side write did not restart")

	// only non-positive energy changes, or lucky positive ones, are accepted
	`ISM_ASSERT_HOLDS(a_accept_de, result_valid && result_accepted, (result_energy_change == -5'sd8) || (result_energy_change == -5'sd4) || (result_energy_change == 5'sd0) || (result_energy_change == 5'sd4) || (result_energy_change == 5'sd8), "accepted flip with bad dE")

	// a rejected request shows zero or a positive change
	`ISM_ASSERT_HOLDS(a_reject_de, result_valid && !result_accepted, (result_energy_change == 5'sd0) || (result_energy_change == 5'sd4) || (result_energy_change == 5'sd8), "rejected flip with bad dE")
endmodule

bind ising_metropolis_spin_update ism_checker u_ism_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.item_valid           (item.valid),
	.item_ready           (item.ready),
	.result_valid         (result.valid),
	.result_accepted      (result.accepted),
	.result_energy_change (result.energy_change),
	.psel                 (psel),
	.penable              (penable),
	.pwrite               (pwrite),
	.paddr                (paddr)
);
